@@ src/crce_pkg.sv @@
`default_nettype none

package crce_pkg;

    // Widest CRC the datapath carries
    localparam int unsigned MAX_WIDTH = 32;
    localparam int unsigned CRC_W     = (MAX_WIDTH < 32) ? MAX_WIDTH : 32;
    localparam int unsigned MIN_WIDTH = 4;
    localparam int unsigned SH_W      = $clog2(CRC_W);
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 32;
    localparam int unsigned BYTE_W    = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CRC_WIDTH  = 3'd0,
        CFG_POLYNOMIAL = 3'd1,
        CFG_INIT_VALUE = 3'd2,
        CFG_FINAL_XOR  = 3'd3,
        CFG_REFLECT    = 3'd4
    } t_cfg_idx;

    localparam logic [5:0]       RST_CRC_WIDTH  = 6'd32;
    localparam logic [CRC_W-1:0] RST_POLYNOMIAL = CRC_W'(32'h04C1_1DB7);
    localparam logic [CRC_W-1:0] RST_INIT_VALUE = CRC_W'(32'hFFFF_FFFF);
    localparam logic [CRC_W-1:0] RST_FINAL_XOR  = CRC_W'(32'hFFFF_FFFF);
    localparam logic             RST_REFLECT    = 1'b1;

    // Per-byte view of the configuration, shared by every cell
    typedef struct packed {
        logic             refl;
        logic [SH_W-1:0]  sh;       // CRC_W minus effective width
        logic [CRC_W-1:0] poly_al;  // normal polynomial, top-aligned
        logic [CRC_W-1:0] poly_rf;  // reflected polynomial, LSB-aligned
    } t_crc_cfg;

    function automatic logic [5:0] eff_width(input logic [5:0] w);
        logic [5:0] r;
        r = w;
        if (r < 6'(MIN_WIDTH)) r = 6'(MIN_WIDTH);
        if (r > 6'(CRC_W))     r = 6'(CRC_W);
        return r;
    endfunction

    function automatic logic [CRC_W-1:0] bit_reverse(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int i = 0; i < int'(CRC_W); i++) begin
            r[i] = v[CRC_W-1-i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/crce_cell.sv @@
`default_nettype none

// One bit step of the LFSR over the full register word.
module crce_cell (
    input  wire logic [crce_pkg::CRC_W-1:0] i_reg,
    input  wire logic                       i_bit,
    input  wire crce_pkg::t_crc_cfg         i_cfg,
    output logic      [crce_pkg::CRC_W-1:0] o_reg
);

    logic fb;

    always_comb begin
        if (i_cfg.refl) begin
            fb    = i_reg[0] ^ i_bit;
            o_reg = (i_reg >> 1) ^ (fb ? i_cfg.poly_rf : '0);
        end else begin
            fb    = i_reg[crce_pkg::CRC_W-1] ^ i_bit;
            o_reg = (i_reg << 1) ^ (fb ? i_cfg.poly_al : '0);
        end
    end

endmodule

`default_nettype wire

@@ src/crce_chain.sv @@
`default_nettype none

// Row of eight bit cells folding one byte; handles alignment in and out.
module crce_chain (
    input  wire logic [crce_pkg::CRC_W-1:0]  i_state,
    input  wire logic [crce_pkg::CRC_W-1:0]  i_init_al,
    input  wire logic                        i_first,
    input  wire logic [crce_pkg::BYTE_W-1:0] i_byte,
    input  wire crce_pkg::t_crc_cfg          i_cfg,
    output logic      [crce_pkg::CRC_W-1:0]  o_state
);

    logic [crce_pkg::CRC_W-1:0] tap [crce_pkg::BYTE_W+1];
    logic [crce_pkg::CRC_W-1:0] state_al;
    logic [crce_pkg::CRC_W-1:0] mask;

    // reflected state is LSB-aligned: clear bits left over from a wider width
    assign mask     = {crce_pkg::CRC_W{1'b1}} >> i_cfg.sh;
    assign state_al = i_cfg.refl ? (i_state & mask) : (i_state << i_cfg.sh);
    assign tap[0]   = i_first ? i_init_al : state_al;

    for (genvar g = 0; g < crce_pkg::BYTE_W; g++) begin : g_cell
        logic bit_in;
        assign bit_in = i_cfg.refl ? i_byte[g] : i_byte[crce_pkg::BYTE_W-1-g];
        crce_cell u_cell (
            .i_reg (tap[g]),
            .i_bit (bit_in),
            .i_cfg (i_cfg),
            .o_reg (tap[g+1])
        );
    end

    assign o_state = i_cfg.refl ? tap[crce_pkg::BYTE_W]
                                : (tap[crce_pkg::BYTE_W] >> i_cfg.sh);

endmodule

`default_nettype wire

@@ src/configurable_crc_engine.sv @@
// A last-byte result goes into the output register, or into the skid entry if that is not free.
// One byte request per cycle while the skid is empty; the eight-cell LFSR row is combinational.
// A two-entry output stage (output register plus skid) keeps input flowing while a result waits.
// Reset (synchronous, active low): config registers go to their defaults (CRC-32, reflected),
// the running remainder clears to zero and both output entries are emptied.
`default_nettype none

module configurable_crc_engine (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // byte requests
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [7:0]                          i_data_byte,
    input  wire logic                                i_first_byte,
    input  wire logic                                i_last_byte,
    // results
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic      [31:0]                         o_crc_value,
    // configuration writes
    input  wire logic                                i_cfg_we,
    input  wire logic [crce_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [crce_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    localparam int unsigned W = crce_pkg::CRC_W;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [5:0]   r_crc_width;
    logic [W-1:0] r_polynomial;
    logic [W-1:0] r_init_value;
    logic [W-1:0] r_final_xor;
    logic         r_reflect;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_width  <= crce_pkg::RST_CRC_WIDTH;
            r_polynomial <= crce_pkg::RST_POLYNOMIAL;
            r_init_value <= crce_pkg::RST_INIT_VALUE;
            r_final_xor  <= crce_pkg::RST_FINAL_XOR;
            r_reflect    <= crce_pkg::RST_REFLECT;
        end else if (i_cfg_we) begin
            unique case (crce_pkg::t_cfg_idx'(i_cfg_index))
                crce_pkg::CFG_CRC_WIDTH:  r_crc_width  <= i_cfg_data[5:0];
                crce_pkg::CFG_POLYNOMIAL: r_polynomial <= i_cfg_data[W-1:0];
                crce_pkg::CFG_INIT_VALUE: r_init_value <= i_cfg_data[W-1:0];
                crce_pkg::CFG_FINAL_XOR:  r_final_xor  <= i_cfg_data[W-1:0];
                crce_pkg::CFG_REFLECT:    r_reflect    <= i_cfg_data[0];
                default: ;  // unknown index: ignored
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Derived configuration (depends only on config registers)
    // Normal mode works top-aligned in the 32-bit word, so the shift
    // feedback always comes from the MSB; reflected mode stays LSB-aligned.
    // Bits above the width drop out through the alignment shifts.
    // ---------------------------------------------------------------
    logic [5:0]         eff_w;
    logic [W-1:0]       mask;
    logic [W-1:0]       init_al;
    crce_pkg::t_crc_cfg cfg;

    always_comb begin
        eff_w        = crce_pkg::eff_width(r_crc_width);
        cfg.refl     = r_reflect;
        cfg.sh       = crce_pkg::SH_W'(6'(W) - eff_w);
        cfg.poly_al  = r_polynomial << cfg.sh;
        cfg.poly_rf  = crce_pkg::bit_reverse(r_polynomial) >> cfg.sh;
        mask         = {W{1'b1}} >> cfg.sh;
        // reflected start loads the mirrored init value
        init_al      = r_reflect ? (crce_pkg::bit_reverse(r_init_value) >> cfg.sh)
                                 : (r_init_value << cfg.sh);
    end

    // ---------------------------------------------------------------
    // Running remainder and byte fold
    // ---------------------------------------------------------------
    logic [W-1:0] r_crc_reg;
    logic [W-1:0] n_crc_reg;
    logic         in_fire;

    crce_chain u_chain (
        .i_state   (r_crc_reg),
        .i_init_al (init_al),
        .i_first   (i_first_byte),
        .i_byte    (i_data_byte),
        .i_cfg     (cfg),
        .o_state   (n_crc_reg)
    );

    assign in_fire = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_reg <= '0;
        end else if (in_fire) begin
            r_crc_reg <= n_crc_reg;
        end
    end

    // ---------------------------------------------------------------
    // Output register plus skid entry
    // ---------------------------------------------------------------
    logic         r_out_valid;
    logic [W-1:0] r_out_data;
    logic         r_skid_valid;
    logic [W-1:0] r_skid_data;
    logic         push;
    logic [W-1:0] push_data;
    logic         out_free;

    assign push      = in_fire && i_last_byte;
    assign push_data = (n_crc_reg ^ r_final_xor) & mask;
    assign out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_out_data   <= r_skid_data;
                    r_skid_valid <= push;
                    r_skid_data  <= push_data;
                end else begin
                    r_out_valid  <= push;
                    r_out_data   <= push_data;
                end
            end else if (push) begin
                // output held; skid is empty because input was ready
                r_skid_valid <= 1'b1;
                r_skid_data  <= push_data;
            end
        end
    end

    assign o_in_ready  = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_crc_value = 32'(r_out_data);

endmodule

`default_nettype wire
